@@ sv/ising_metropolis_spin_update_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the Ising spin update block
// Shorthand for clocked implication checks with an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ISING_METROPOLIS_SPIN_UPDATE_MACROS_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define ISMU_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define ISMU_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ismu_pkg.sv @@
// ---------------------------------------------------------------------------
// Ising spin update package
// Lattice size, field widths, register indexes, shared types and helpers.
// ---------------------------------------------------------------------------
package ismu_pkg;

    localparam int SIDE    = 64;
    localparam int IDX_W   = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int COORD_W = 6;
    localparam int FRAC_W  = 32;
    localparam int DE_W    = 5;
    localparam int MAG_W   = 14;
    localparam int BOND_W  = 15;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_FOUR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_EIGHT = 1'b1;

    localparam logic CMD_FLIP = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    localparam logic [FRAC_W-1:0] LIMIT_FOUR_RESET  = 32'd78665071;
    localparam logic [FRAC_W-1:0] LIMIT_EIGHT_RESET = 32'd1440802;

    localparam logic signed [MAG_W-1:0]  MAG_RESET  = MAG_W'(SIDE * SIDE);
    localparam logic signed [BOND_W-1:0] BOND_RESET = BOND_W'(-2 * SIDE * SIDE);
    localparam logic signed [DE_W-1:0]   DE_MINUS_FOUR = DE_W'(-4);
    localparam logic signed [MAG_W-1:0]  MAG_STEP = MAG_W'(2);

    typedef logic [SIDE-1:0]  row_t;
    typedef logic [IDX_W-1:0] idx_t;

    // Item as held by the sequencer while its rows are fetched
    typedef struct packed {
        logic              cmd;
        logic              want;
        idx_t              col;
        logic [FRAC_W-1:0] frac;
    } site_t;

    typedef struct packed {
        logic                      accepted;
        logic                      spin_now;
        logic signed [DE_W-1:0]    energy_term;
        logic signed [MAG_W-1:0]   magnetization;
        logic signed [BOND_W-1:0]  bond_energy;
    } result_t;

    function automatic idx_t wrap_idx(input logic [COORD_W-1:0] v);
        return idx_t'(32'(v) % SIDE);
    endfunction

    function automatic idx_t idx_dec(input idx_t i);
        return (i == idx_t'(0)) ? idx_t'(SIDE - 1) : idx_t'(i - 1'b1);
    endfunction

    function automatic idx_t idx_inc(input idx_t i);
        return (i == idx_t'(SIDE - 1)) ? idx_t'(0) : idx_t'(i + 1'b1);
    endfunction

endpackage

@@ sv/ismu_lattice_mem.sv @@
// ---------------------------------------------------------------------------
// Lattice row memory
// One row of spins per entry, two registered read ports, one write port.
// Rows never written read as all spins up.
// ---------------------------------------------------------------------------
module ismu_lattice_mem (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rd_en_a,
    input  ismu_pkg::idx_t rd_addr_a,
    output ismu_pkg::row_t rd_data_a,
    input  logic           rd_en_b,
    input  ismu_pkg::idx_t rd_addr_b,
    output ismu_pkg::row_t rd_data_b,
    input  logic           wr_en,
    input  ismu_pkg::idx_t wr_addr,
    input  ismu_pkg::row_t wr_data
);
    import ismu_pkg::*;

    row_t            row_mem [SIDE];
    row_t            q_a_reg;
    row_t            q_b_reg;
    logic [SIDE-1:0] valid_reg;
    logic [SIDE-1:0] valid_next;
    logic            q_a_valid_reg;
    logic            q_b_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= wr_data;
        end
        if (rd_en_a)
        begin
            q_a_reg <= row_mem[rd_addr_a];
        end
        if (rd_en_b)
        begin
            q_b_reg <= row_mem[rd_addr_b];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            q_a_valid_reg <= 1'b0;
            q_b_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en_a)
            begin
                q_a_valid_reg <= valid_reg[rd_addr_a];
            end
            if (rd_en_b)
            begin
                q_b_valid_reg <= valid_reg[rd_addr_b];
            end
        end
    end

    assign rd_data_a = q_a_valid_reg ? q_a_reg : '1;
    assign rd_data_b = q_b_valid_reg ? q_b_reg : '1;

endmodule

@@ sv/ismu_update.sv @@
// ---------------------------------------------------------------------------
// Spin update unit
// Energy term, Metropolis decision, new row and running totals.
// ---------------------------------------------------------------------------
module ismu_update (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          commit,
    input  ismu_pkg::site_t               site,
    input  ismu_pkg::row_t                row_up,
    input  ismu_pkg::row_t                row_mid,
    input  ismu_pkg::row_t                row_dn,
    input  logic [ismu_pkg::FRAC_W-1:0]   limit_four,
    input  logic [ismu_pkg::FRAC_W-1:0]   limit_eight,
    output ismu_pkg::row_t                row_new,
    output ismu_pkg::result_t             result
);
    import ismu_pkg::*;

    logic signed [MAG_W-1:0]  mag_reg;
    logic signed [MAG_W-1:0]  mag_next;
    logic signed [BOND_W-1:0] bond_reg;
    logic signed [BOND_W-1:0] bond_next;

    logic                   s_bit;
    logic [2:0]             n_up;
    logic signed [5:0]      de_wide;
    logic signed [DE_W-1:0] de;
    logic                   flip;
    logic                   spin_new;

    assign s_bit = row_mid[site.col];

    // Count of up neighbours; the neighbour sum is 2*n_up - 4
    assign n_up = {2'b00, row_up[site.col]} + {2'b00, row_dn[site.col]}
                + {2'b00, row_mid[idx_dec(site.col)]}
                + {2'b00, row_mid[idx_inc(site.col)]};

    // de = -2*s*sum: 8 - 4*n_up for an up spin, negated for a down spin
    assign de_wide = 6'sd8 - $signed({1'b0, n_up, 2'b00});
    assign de      = s_bit ? DE_W'(de_wide) : DE_W'(-de_wide);

    always_comb
    begin
        if (site.cmd == CMD_SET)
        begin
            flip = (site.want != s_bit);
        end
        else if (!de[DE_W-1])
        begin
            flip = 1'b1;
        end
        else if (de == DE_MINUS_FOUR)
        begin
            flip = (site.frac < limit_four);
        end
        else
        begin
            flip = (site.frac < limit_eight);
        end
    end

    assign spin_new = s_bit ^ flip;

    always_comb
    begin
        row_new           = row_mid;
        row_new[site.col] = spin_new;
    end

    always_comb
    begin
        mag_next  = mag_reg;
        bond_next = bond_reg;
        if (flip)
        begin
            mag_next  = s_bit ? (mag_reg - MAG_STEP) : (mag_reg + MAG_STEP);
            bond_next = bond_reg - BOND_W'(de);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg  <= MAG_RESET;
            bond_reg <= BOND_RESET;
        end
        else if (commit)
        begin
            mag_reg  <= mag_next;
            bond_reg <= bond_next;
        end
    end

    assign result.accepted      = flip;
    assign result.spin_now      = spin_new;
    assign result.energy_term   = de;
    assign result.magnetization = mag_next;
    assign result.bond_energy   = bond_next;

endmodule

@@ sv/ising_metropolis_spin_update.sv @@
// ---------------------------------------------------------------------------
// Ising Metropolis spin update
// Periodic 64 x 64 lattice of one-bit spins with single-site updates.
// ---------------------------------------------------------------------------
// Each input transfer is either a Metropolis flip attempt (tuser = 0) or a
// direct spin write (tuser = 1) at one site; every item returns exactly one
// result transfer carrying the flip flag, the spin after the step, the
// energy term de taken before the step and the running magnetization and
// bond energy totals. The lattice sits in a row-wide memory with two
// registered read ports. An item needs its own row and the rows above
// and below, so it steps through acceptance (rows above and below
// fetched), a state that fetches its own row, and a state that evaluates
// and writes the row back; the next item is accepted in the cycle after
// write-back, so only one item is in progress at a time. A finished result
// waits in an output register and the next item is still accepted;
// evaluation holds only when that register is full and not being taken.
// Reset makes every spin up at once (per-row valid bits) with totals 4096
// and -8192. Configuration writes are always taken; change the limits only
// while the block is idle.
// ---------------------------------------------------------------------------
module ising_metropolis_spin_update (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream. tdata: row[5:0], col[11:6], rand_fraction[43:12],
    // spin_value[44], zero[47:45]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ismu_pkg::IN_TDATA_W-1:0]    s_tdata,
    // tuser: cmd[0]
    input  logic                               s_tuser,
    // Result stream. tdata: accepted[0], spin_now[1], energy_term[6:2],
    // magnetization[20:7], bond_energy[35:21], zero[39:36]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ismu_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // Configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ismu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ismu_pkg::FRAC_W-1:0]        cfg_data
);
    import ismu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ_MID,
        ST_EVAL
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    logic    m_tvalid_reg;
    logic    m_tvalid_next;
    result_t result_reg;
    result_t result_next;

    logic [FRAC_W-1:0] limit_four_reg;
    logic [FRAC_W-1:0] limit_eight_reg;

    site_t site_reg;
    idx_t  r_reg;
    row_t  up_row_reg;

    logic  s_xfer;
    logic  commit;
    idx_t  in_r;
    site_t in_site;

    logic  rd_en_a;
    logic  rd_en_b;
    idx_t  rd_addr_a;
    idx_t  rd_addr_b;
    row_t  rd_data_a;
    row_t  rd_data_b;
    row_t  row_new;
    result_t upd_result;

    // Unpack the input transfer; coordinates wrap onto the lattice
    assign in_r         = wrap_idx(s_tdata[5:0]);
    assign in_site.cmd  = s_tuser;
    assign in_site.want = s_tdata[44];
    assign in_site.col  = wrap_idx(s_tdata[11:6]);
    assign in_site.frac = s_tdata[43:12];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    // Evaluate only when the output register can take the result
    assign commit = (state_reg == ST_EVAL) && (!m_tvalid_reg || m_tready);

    // Port a: row above at transfer, own row in the READ_MID state.
    // Port b: row below at transfer, then held through evaluation.
    assign rd_en_a   = s_xfer || (state_reg == ST_READ_MID);
    assign rd_addr_a = (state_reg == ST_IDLE) ? idx_dec(in_r) : r_reg;
    assign rd_en_b   = s_xfer;
    assign rd_addr_b = idx_inc(in_r);

    ismu_lattice_mem u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en_a   (rd_en_a),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_en_b   (rd_en_b),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b),
        .wr_en     (commit),
        .wr_addr   (r_reg),
        .wr_data   (row_new)
    );

    ismu_update u_upd (
        .clk         (clk),
        .rst_n       (rst_n),
        .commit      (commit),
        .site        (site_reg),
        .row_up      (up_row_reg),
        .row_mid     (rd_data_a),
        .row_dn      (rd_data_b),
        .limit_four  (limit_four_reg),
        .limit_eight (limit_eight_reg),
        .row_new     (row_new),
        .result      (upd_result)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    state_next = ST_READ_MID;
                end
            end
            ST_READ_MID:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Load a new result on evaluation, drop the old one once transferred
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        result_next   = result_reg;
        if (commit)
        begin
            m_tvalid_next = 1'b1;
            result_next   = upd_result;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            result_reg   <= result_next;
        end
    end

    // Item payload held for the duration of the update
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            r_reg    <= in_r;
            site_reg <= in_site;
        end
        if (state_reg == ST_READ_MID)
        begin
            up_row_reg <= rd_data_a;
        end
    end

    // Acceptance limits
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_four_reg  <= LIMIT_FOUR_RESET;
            limit_eight_reg <= LIMIT_EIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_LIMIT_FOUR)
            begin
                limit_four_reg <= cfg_data;
            end
            else if (cfg_index == CFG_LIMIT_EIGHT)
            begin
                limit_eight_reg <= cfg_data;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000,
                       result_reg.bond_energy,
                       result_reg.magnetization,
                       result_reg.energy_term,
                       result_reg.spin_now,
                       result_reg.accepted};

endmodule

@@ sv/ismu_checker.sv @@
// ---------------------------------------------------------------------------
// Ising spin update port checker
// Watches the stream ports of the top level for handshake and value slips.
// ---------------------------------------------------------------------------
`include "ising_metropolis_spin_update_macros.svh"

module ismu_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [ismu_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import ismu_pkg::*;

    // A stalled result holds
    `ISMU_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    // One item at a time: no transfer right after a transfer
    `ISMU_ASSERT_NEXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready, "input taken while an item is in progress")
    // de is one of -8, -4, 0, 4, 8
    `ISMU_ASSERT_IMPLY(a_de_range, clk, rst_n, m_tvalid, (m_tdata[3:2] == 2'b00) && ((m_tdata[6:4] == 3'b110) || (m_tdata[6:4] == 3'b111) || (m_tdata[6:4] == 3'b000) || (m_tdata[6:4] == 3'b001) || (m_tdata[6:4] == 3'b010)), "energy term out of range")
    // Magnetization moves in steps of two, bond energy in steps of four
    `ISMU_ASSERT_IMPLY(a_totals_step, clk, rst_n, m_tvalid, !m_tdata[7] && (m_tdata[22:21] == 2'b00), "running total lost its step size")

endmodule

bind ising_metropolis_spin_update ismu_checker u_ismu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
